@@ hw/rtl/aff2d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_pkg
// Shared types, constants and elaboration-time functions of the 2D point
// transform: payload words, register indexes, CORDIC tables and gain.
// ----------------------------------------------------------------------------
package aff2d_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEPS_MAX        = 32;
    localparam int CNT_W            = 6;
    localparam int CFG_W            = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int M_W              = 52;   // rounded dividend
    localparam int DIV_BITS         = 32;   // quotient bits resolved by the pipeline

    localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;
    localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
    localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;
    localparam logic signed [31:0] ONE_Q16     = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TX    = 3'd0,
        CFG_TY    = 3'd1,
        CFG_ANGLE = 3'd2,
        CFG_SX    = 3'd3,
        CFG_SY    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               to_local;
    } t_point_in;

    typedef struct packed {
        logic signed [31:0] result_x;
        logic signed [31:0] result_y;
        logic               overflow;
    } t_point_out;

    // cos and sin as magnitude and sign, Q30
    typedef struct packed {
        logic [30:0] cos_mag;
        logic        cos_neg;
        logic [30:0] sin_mag;
        logic        sin_neg;
    } t_trig;

    // one coordinate on its way into the divider
    typedef struct packed {
        logic [M_W-1:0] m;
        logic [31:0]    d;
        logic           neg;
        logic           big;
    } t_div_lane;

    function automatic logic [31:0] atan_q28(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd210828714;
            5'd1:  v = 32'd124459457;
            5'd2:  v = 32'd65760959;
            5'd3:  v = 32'd33381290;
            5'd4:  v = 32'd16755422;
            5'd5:  v = 32'd8385879;
            5'd6:  v = 32'd4193963;
            5'd7:  v = 32'd2097109;
            5'd8:  v = 32'd1048571;
            5'd9:  v = 32'd524287;
            5'd10: v = 32'd262144;
            5'd11: v = 32'd131072;
            5'd12: v = 32'd65536;
            5'd13: v = 32'd32768;
            5'd14: v = 32'd16384;
            5'd15: v = 32'd8192;
            5'd16: v = 32'd4096;
            5'd17: v = 32'd2048;
            5'd18: v = 32'd1024;
            5'd19: v = 32'd512;
            5'd20: v = 32'd256;
            5'd21: v = 32'd128;
            5'd22: v = 32'd64;
            5'd23: v = 32'd32;
            5'd24: v = 32'd16;
            5'd25: v = 32'd8;
            5'd26: v = 32'd4;
            5'd27: v = 32'd2;
            5'd28: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // square root, in Q30, of the CORDIC gain product held in Q60, never zero,
    // evaluated at elaboration only
    function automatic logic [63:0] cordic_root(input int steps);
        logic [63:0] g2;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int i;
        g2 = 64'd1 << 30;
        for (i = 0; i < steps; i++) begin
            g2 = g2 + (g2 >> (2 * i));
        end
        v = g2 << 30;
        r = 64'd0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return (r == 64'd0) ? 64'd1 : r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/aff2d_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface aff2d_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/aff2d_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_cordic
// Sequential rotation-mode CORDIC: turns the angle register into cos and sin,
// one micro-rotation per cycle, after reset and after every angle write.
// ----------------------------------------------------------------------------
module aff2d_cordic #(
    parameter int STEPS = aff2d_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_angle,
    output      logic               o_busy,
    output      aff2d_pkg::t_trig   o_trig
);
    import aff2d_pkg::*;

    localparam int          NSTEPS = (STEPS > STEPS_MAX) ? STEPS_MAX : STEPS;
    localparam logic [63:0] ROOT   = cordic_root(NSTEPS);
    localparam logic [31:0] GAIN   = 32'(((64'd1 << 60) + (ROOT >> 1)) / ROOT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_RUN  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic signed [32:0]      r_x, r_y, r_z, n_x, n_y, n_z;
    logic                    r_neg, n_neg;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    t_trig                   r_trig, n_trig;

    logic signed [32:0] z0, z1, xs, ys, at, cx, cy;

    always_comb begin
        z0 = {i_angle[15], i_angle, 16'b0};
        if (z0 > ANG_PI) begin
            z1 = z0 - ANG_TWO_PI;
        end else if (z0 < -ANG_PI) begin
            z1 = z0 + ANG_TWO_PI;
        end else begin
            z1 = z0;
        end
        xs = r_x >>> r_cnt[4:0];
        ys = r_y >>> r_cnt[4:0];
        at = signed'({1'b0, atan_q28(r_cnt[4:0])});
        cx = (r_x > ONE_Q30) ? ONE_Q30 : ((r_x < -ONE_Q30) ? -ONE_Q30 : r_x);
        cy = (r_y > ONE_Q30) ? ONE_Q30 : ((r_y < -ONE_Q30) ? -ONE_Q30 : r_y);

        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_trig  = r_trig;
        case (r_state)
            S_INIT: begin
                n_x   = signed'({1'b0, GAIN});
                n_y   = '0;
                n_cnt = '0;
                // fold beyond a quarter turn and flip both results
                if (z1 > ANG_HALF_PI) begin
                    n_z   = z1 - ANG_PI;
                    n_neg = 1'b1;
                end else if (z1 < -ANG_HALF_PI) begin
                    n_z   = z1 + ANG_PI;
                    n_neg = 1'b1;
                end else begin
                    n_z   = z1;
                    n_neg = 1'b0;
                end
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_z >= 0) begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - at;
                end else begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + at;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NSTEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_trig.cos_mag = 31'(cx[32] ? -cx : cx);
                n_trig.cos_neg = cx[32] ^ r_neg;
                n_trig.sin_mag = 31'(cy[32] ? -cy : cy);
                n_trig.sin_neg = cy[32] ^ r_neg;
                n_state        = S_IDLE;
            end
            S_IDLE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_start) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_neg  <= n_neg;
        r_cnt  <= n_cnt;
        r_trig <= n_trig;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_trig = r_trig;

endmodule
`default_nettype wire

@@ hw/rtl/aff2d_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_datapath
// Seven register stages: scale or untranslate, magnitude, split rotate
// products, recombine, sum, and preparation of the rounded dividend.
// ----------------------------------------------------------------------------
module aff2d_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire aff2d_pkg::t_point_in      i_pt,
    input  wire logic signed [31:0]        i_tx,
    input  wire logic signed [31:0]        i_ty,
    input  wire logic signed [31:0]        i_sx,
    input  wire logic signed [31:0]        i_sy,
    input  wire aff2d_pkg::t_trig          i_trig,
    output      logic                      o_valid,
    output      aff2d_pkg::t_div_lane [1:0] o_lane
);
    import aff2d_pkg::*;

    logic signed [31:0] sx_eff, sy_eff;
    logic [31:0]        sx_mag, sy_mag;

    assign sx_eff = (i_sx == 32'sd0) ? ONE_Q16 : i_sx;
    assign sy_eff = (i_sy == 32'sd0) ? ONE_Q16 : i_sy;
    assign sx_mag = sx_eff[31] ? 32'(-sx_eff) : 32'(sx_eff);
    assign sy_mag = sy_eff[31] ? 32'(-sy_eff) : 32'(sy_eff);

    logic [7:1] r_v;

    // stage 1
    logic               r1_dir;
    logic signed [63:0] r1_prod [2];
    logic signed [32:0] r1_diff [2];
    // stage 2
    logic               r2_dir;
    logic [46:0]        r2_mag [2];
    logic               r2_sgn [2];
    // stage 3
    logic               r3_dir;
    logic [62:0]        r3_lo [4];
    logic [45:0]        r3_hi [4];
    logic               r3_sgn [4];
    // stage 4
    logic               r4_dir;
    logic signed [49:0] r4_p [4];
    // stage 5
    logic               r5_dir;
    logic signed [50:0] r5_w [2];
    // stage 6
    logic [M_W-1:0]     r6_n [2];
    logic [31:0]        r6_d [2];
    logic               r6_neg [2];
    // stage 7
    t_div_lane [1:0]    r7_lane;

    logic [63:0]        pm [2];
    logic [32:0]        dm [2];
    logic [46:0]        am [4];
    logic [30:0]        tm [4];
    logic               as [4];
    logic               ts [4];
    logic [49:0]        pmag [4];
    logic [50:0]        wm [2];
    logic [M_W-1:0]     msum [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pm[l] = r1_prod[l][63] ? 64'(-r1_prod[l]) : 64'(r1_prod[l]);
            dm[l] = r1_diff[l][32] ? 33'(-r1_diff[l]) : 33'(r1_diff[l]);
            wm[l] = r5_w[l][50] ? 51'(-r5_w[l]) : 51'(r5_w[l]);
            msum[l] = r6_n[l] + M_W'(r6_d[l] >> 1);
        end
        // products 0..3: a0*c, a1*s, a0*s, a1*c
        for (int k = 0; k < 4; k++) begin
            am[k] = (k == 0 || k == 2) ? r2_mag[0] : r2_mag[1];
            as[k] = (k == 0 || k == 2) ? r2_sgn[0] : r2_sgn[1];
            tm[k] = (k == 0 || k == 3) ? i_trig.cos_mag : i_trig.sin_mag;
            ts[k] = (k == 0 || k == 3) ? i_trig.cos_neg : i_trig.sin_neg;
            pmag[k] = 50'({r3_hi[k], 2'b00}) +
                      50'((64'(r3_lo[k]) + 64'd536870912) >> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
        if (i_en) begin
            // stage 1
            r1_dir     <= i_pt.to_local;
            r1_prod[0] <= 64'(sx_eff) * 64'(i_pt.point_x);
            r1_prod[1] <= 64'(sy_eff) * 64'(i_pt.point_y);
            r1_diff[0] <= 33'(i_pt.point_x) - 33'(i_tx);
            r1_diff[1] <= 33'(i_pt.point_y) - 33'(i_ty);
            // stage 2
            r2_dir <= r1_dir;
            for (int l = 0; l < 2; l++) begin
                if (r1_dir) begin
                    r2_mag[l] <= 47'(dm[l]);
                    r2_sgn[l] <= r1_diff[l][32];
                end else begin
                    r2_mag[l] <= 47'((pm[l] + 64'd32768) >> 16);
                    r2_sgn[l] <= r1_prod[l][63];
                end
            end
            // stage 3
            r3_dir <= r2_dir;
            for (int k = 0; k < 4; k++) begin
                r3_lo[k]  <= 63'(am[k][31:0]) * 63'(tm[k]);
                r3_hi[k]  <= 46'(am[k][46:32]) * 46'(tm[k]);
                r3_sgn[k] <= as[k] ^ ts[k];
            end
            // stage 4
            r4_dir <= r3_dir;
            for (int k = 0; k < 4; k++) begin
                r4_p[k] <= r3_sgn[k] ? -signed'(pmag[k]) : signed'(pmag[k]);
            end
            // stage 5
            r5_dir <= r4_dir;
            if (r4_dir) begin
                r5_w[0] <= 51'(r4_p[0]) + 51'(r4_p[1]);
                r5_w[1] <= 51'(r4_p[3]) - 51'(r4_p[2]);
            end else begin
                r5_w[0] <= 51'(r4_p[0]) - 51'(r4_p[1]) + 51'(i_tx);
                r5_w[1] <= 51'(r4_p[2]) + 51'(r4_p[3]) + 51'(i_ty);
            end
            // stage 6
            for (int l = 0; l < 2; l++) begin
                if (r5_dir) begin
                    r6_n[l] <= M_W'({wm[l], 16'b0});
                    r6_d[l] <= (l == 0) ? sx_mag : sy_mag;
                    r6_neg[l] <= r5_w[l][50] ^ ((l == 0) ? sx_eff[31] : sy_eff[31]);
                end else begin
                    r6_n[l]   <= M_W'(wm[l]);
                    r6_d[l]   <= 32'd1;
                    r6_neg[l] <= r5_w[l][50];
                end
            end
            // stage 7: add half the divisor, flag quotients of 2^32 and more
            for (int l = 0; l < 2; l++) begin
                r7_lane[l].m   <= msum[l];
                r7_lane[l].d   <= r6_d[l];
                r7_lane[l].neg <= r6_neg[l];
                r7_lane[l].big <= (64'(msum[l]) >= {r6_d[l], 32'b0});
            end
        end
    end

    assign o_valid = r_v[7];
    assign o_lane  = r7_lane;

endmodule
`default_nettype wire

@@ hw/rtl/aff2d_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_divider
// Pipelined restoring divider, one quotient bit per stage for both
// coordinates, followed by a signed saturation stage.
// ----------------------------------------------------------------------------
module aff2d_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire aff2d_pkg::t_div_lane [1:0] i_lane,
    output      logic                       o_valid,
    output      aff2d_pkg::t_point_out      o_res
);
    import aff2d_pkg::*;

    typedef struct packed {
        logic [M_W-1:0] rem;
        logic [31:0]    q;
        logic [31:0]    d;
        logic           neg;
        logic           big;
    } t_div_st;

    logic                r_v  [DIV_BITS];
    t_div_st [1:0]       r_st [DIV_BITS];

    for (genvar s = 0; s < DIV_BITS; s++) begin : g_stage
        localparam int J = DIV_BITS - 1 - s;
        logic          p_v;
        t_div_st [1:0] p_st;
        t_div_st [1:0] n_st;
        logic [63:0]   dj [2];
        logic          ge [2];

        if (s == 0) begin : g_first
            assign p_v = i_valid;
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign p_st[l].rem = i_lane[l].m;
                assign p_st[l].q   = '0;
                assign p_st[l].d   = i_lane[l].d;
                assign p_st[l].neg = i_lane[l].neg;
                assign p_st[l].big = i_lane[l].big;
            end
        end else begin : g_next
            assign p_v  = r_v[s-1];
            assign p_st = r_st[s-1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                dj[l] = 64'(p_st[l].d) << J;
                ge[l] = (64'(p_st[l].rem) >= dj[l]);
                n_st[l]     = p_st[l];
                if (ge[l]) begin
                    n_st[l].rem = p_st[l].rem - M_W'(dj[l]);
                    n_st[l].q   = p_st[l].q | (32'd1 << J);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    // saturate to signed 32 bits
    t_div_st [1:0] f_st;
    logic          sat [2];
    logic [31:0]   res [2];
    logic          r_out_v;
    t_point_out    r_out;

    assign f_st = r_st[DIV_BITS-1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (f_st[l].neg) begin
                sat[l] = f_st[l].big || (f_st[l].q > 32'h8000_0000);
                res[l] = sat[l] ? 32'h8000_0000 : 32'(-f_st[l].q);
            end else begin
                sat[l] = f_st[l].big || f_st[l].q[31];
                res[l] = sat[l] ? 32'h7FFF_FFFF : f_st[l].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[DIV_BITS-1];
        end
        if (i_en) begin
            r_out.result_x <= signed'(res[0]);
            r_out.result_y <= signed'(res[1]);
            r_out.overflow <= sat[0] | sat[1];
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/aff2d_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_outq
// Two-word output queue; its registered space flag runs the whole pipeline.
// ----------------------------------------------------------------------------
module aff2d_outq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire aff2d_pkg::t_point_out i_data,
    input  wire logic                  i_pop,
    output      logic                  o_space,
    output      logic                  o_valid,
    output      aff2d_pkg::t_point_out o_data
);
    import aff2d_pkg::*;

    t_point_out r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_data  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/affine_2d_point_transform_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// affine_2d_point_transform_unit
// Scale/rotate/translate of Q16.16 points, forward or inverse per word.
// ----------------------------------------------------------------------------
// One point enters per cycle unless the pipeline halts or input is held off;
// its result passes 7 arithmetic stages, 32 quotient stages of the divider
// and one saturation stage, then the two-word output queue. The pipeline
// halts only when that queue is full. cos and sin are produced by a shared
// iterative CORDIC, one micro-rotation per cycle: after reset and after each
// write to the angle register, input is held off while it runs. Write
// configuration only with the block empty.
// ----------------------------------------------------------------------------
module affine_2d_point_transform_unit #(
    parameter int CORDIC_STEPS = aff2d_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aff2d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [aff2d_pkg::CFG_W-1:0]   i_cfg_wdata,
    aff2d_stream_if.sink                       i_pt,
    aff2d_stream_if.source                     o_res
);
    import aff2d_pkg::*;

    logic signed [31:0] r_tx, r_ty, r_sx, r_sy;
    logic [15:0]        r_angle;

    logic               busy, en, angle_wr;
    t_trig              trig;
    logic               dp_v, dv_v;
    t_div_lane [1:0]    lanes;
    t_point_out         dv_res;

    assign angle_wr = i_cfg_we && (i_cfg_idx == CFG_ANGLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx    <= '0;
            r_ty    <= '0;
            r_angle <= '0;
            r_sx    <= ONE_Q16;
            r_sy    <= ONE_Q16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TX:    r_tx    <= signed'(i_cfg_wdata);
                CFG_TY:    r_ty    <= signed'(i_cfg_wdata);
                CFG_ANGLE: r_angle <= i_cfg_wdata[15:0];
                CFG_SX:    r_sx    <= signed'(i_cfg_wdata);
                CFG_SY:    r_sy    <= signed'(i_cfg_wdata);
                default:   ;
            endcase
        end
    end

    aff2d_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (angle_wr),
        .i_angle (r_angle),
        .o_busy  (busy),
        .o_trig  (trig)
    );

    assign i_pt.ready = en && !busy;

    aff2d_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pt.valid && i_pt.ready),
        .i_pt    (i_pt.data),
        .i_tx    (r_tx),
        .i_ty    (r_ty),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .i_trig  (trig),
        .o_valid (dp_v),
        .o_lane  (lanes)
    );

    aff2d_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dp_v),
        .i_lane  (lanes),
        .o_valid (dv_v),
        .o_res   (dv_res)
    );

    aff2d_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && dv_v),
        .i_data  (dv_res),
        .i_pop   (o_res.ready),
        .o_space (en),
        .o_valid (o_res.valid),
        .o_data  (o_res.data)
    );

endmodule
`default_nettype wire

@@ hw/rtl/aff2d_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// aff2d_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
module aff2d_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_we,
    input wire logic [aff2d_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire aff2d_pkg::t_point_out         i_out_data
);
    import aff2d_pkg::*;

    // a new angle needs fresh cos and sin before any point is taken
    a_angle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_idx == CFG_ANGLE) |=> !i_in_ready)
        else $error("point accepted right after an angle write");

    a_reset_hold: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("point accepted right after reset");

    a_ovf_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid &&
         i_out_data.result_x != 32'sh7FFF_FFFF &&
         i_out_data.result_x != 32'sh8000_0000 &&
         i_out_data.result_y != 32'sh7FFF_FFFF &&
         i_out_data.result_y != 32'sh8000_0000) |-> !i_out_data.overflow)
        else $error("overflow set on an unsaturated word");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result word changed");

endmodule

bind affine_2d_point_transform_unit aff2d_checker u_aff2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
`default_nettype wire
